### design/tab_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tab_pkg
// Shared types and constants of the tinted alpha-over blend unit.
// ----------------------------------------------------------------------------
package tab_pkg;

   // register indexes
   localparam logic [1:0] REG_TINT_RED   = 2'd0;
   localparam logic [1:0] REG_TINT_GREEN = 2'd1;
   localparam logic [1:0] REG_TINT_BLUE  = 2'd2;
   localparam logic [1:0] REG_TINT_ALPHA = 2'd3;

   localparam int         CSR_ADDR_W  = 4;
   localparam logic [7:0] TINT_RESET  = 8'd255;

   // pipeline stages
   localparam int NUM_STAGES = 6;
   localparam int STG_PROD   = 0;
   localparam int STG_MUL    = 1;
   localparam int STG_SUM    = 2;
   localparam int STG_RECIP  = 3;
   localparam int STG_BOUND  = 4;
   localparam int STG_OUT    = 5;

   // fixed-point units and constant dividers
   localparam logic [15:0] UNIT16      = 16'd65025;
   localparam int          NUM_COLOR_W = 32;
   localparam int          NUM_ALPHA_W = 24;
   localparam longint      DIV_COLOR   = 64'd16581375;
   localparam int          SHIFT_COLOR = 48;
   localparam longint      DIV_ALPHA   = 64'd65025;
   localparam int          SHIFT_ALPHA = 40;
   localparam int          NUM_COLORS  = 3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   typedef struct packed {
      rgba_type src;
      rgba_type dst;
   } pixel_pair_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] valid;
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage : tab_pkg
`default_nettype wire

### design/tab_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tab_req_if
// Input channel: source and destination RGBA8 pixel, valid/ready.
// ----------------------------------------------------------------------------
interface tab_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_red;
   logic [7:0] src_green;
   logic [7:0] src_blue;
   logic [7:0] src_alpha;
   logic [7:0] dst_red;
   logic [7:0] dst_green;
   logic [7:0] dst_blue;
   logic [7:0] dst_alpha;

   modport source (
      output valid, src_red, src_green, src_blue, src_alpha,
             dst_red, dst_green, dst_blue, dst_alpha,
      input  ready
   );

   modport sink (
      input  valid, src_red, src_green, src_blue, src_alpha,
             dst_red, dst_green, dst_blue, dst_alpha,
      output ready
   );
endinterface : tab_req_if
`default_nettype wire

### design/tab_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tab_rsp_if
// Result channel: blended RGBA8 pixel, valid/ready.
// ----------------------------------------------------------------------------
interface tab_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha,
      output ready
   );
endinterface : tab_rsp_if
`default_nettype wire

### design/tab_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tab_csr
// APB register file holding the four tint factors.
// ----------------------------------------------------------------------------
module tab_csr import tab_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready,
   output      rgba_type              tint
);

   rgba_type   tint_ff;
   rgba_type   tint_in;
   logic [1:0] index;
   logic       wr_en;

   assign index  = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign tint   = tint_ff;

   always_comb begin
      tint_in = tint_ff;
      if (wr_en) begin
         case (index)
            REG_TINT_RED:   tint_in.red   = pwdata[7:0];
            REG_TINT_GREEN: tint_in.green = pwdata[7:0];
            REG_TINT_BLUE:  tint_in.blue  = pwdata[7:0];
            REG_TINT_ALPHA: tint_in.alpha = pwdata[7:0];
            default:        tint_in = tint_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_TINT_RED:   prdata = {24'd0, tint_ff.red};
         REG_TINT_GREEN: prdata = {24'd0, tint_ff.green};
         REG_TINT_BLUE:  prdata = {24'd0, tint_ff.blue};
         REG_TINT_ALPHA: prdata = {24'd0, tint_ff.alpha};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff <= '{red: TINT_RESET, green: TINT_RESET,
                      blue: TINT_RESET, alpha: TINT_RESET};
      end else begin
         tint_ff <= tint_in;
      end
   end

endmodule : tab_csr
`default_nettype wire

### design/tab_pipe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tab_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module tab_pipe_ctrl import tab_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output      logic     in_ready,
   output      logic     out_valid,
   input  wire logic     out_ready,
   output pipe_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready   = load[0];
   assign out_valid  = valid_ff[NUM_STAGES-1];
   assign ctrl.valid = valid_ff;
   assign ctrl.load  = load;

endmodule : tab_pipe_ctrl
`default_nettype wire

### design/tab_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tab_front
// Stages 1-3: effective alpha, tinted products and blend numerators.
// ----------------------------------------------------------------------------
module tab_front import tab_pkg::*; (
   input  wire logic                                  clock,
   input  wire pipe_ctrl_type                         ctrl,
   input  wire rgba_type                              tint,
   input  wire pixel_pair_type                        pix,
   output      logic [NUM_COLORS-1:0][NUM_COLOR_W-1:0] num_color,
   output      logic [NUM_ALPHA_W-1:0]                num_alpha
);

   logic [NUM_COLORS-1:0][7:0] tint_c;
   logic [NUM_COLORS-1:0][7:0] src_c;
   logic [NUM_COLORS-1:0][7:0] dst_c;

   // stage 1
   logic [15:0]                 ea_ff;
   logic [NUM_COLORS-1:0][15:0] tsc_ff;
   logic [NUM_COLORS-1:0][15:0] d255_ff;
   logic [7:0]                  da_ff;

   // stage 2
   logic [15:0]                          inv;
   logic [NUM_COLORS-1:0][NUM_COLOR_W-1:0] p_src_ff;
   logic [NUM_COLORS-1:0][NUM_COLOR_W-1:0] p_dst_ff;
   logic [NUM_ALPHA_W-1:0]               pa_src_ff;
   logic [NUM_ALPHA_W-1:0]               pa_dst_ff;

   // stage 3
   logic [NUM_COLORS-1:0][NUM_COLOR_W-1:0] num_color_ff;
   logic [NUM_ALPHA_W-1:0]               num_alpha_ff;

   assign tint_c = {tint.blue, tint.green, tint.red};
   assign src_c  = {pix.src.blue, pix.src.green, pix.src.red};
   assign dst_c  = {pix.dst.blue, pix.dst.green, pix.dst.red};

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_PROD]) begin
         ea_ff <= {8'd0, tint.alpha} * {8'd0, pix.src.alpha};
         da_ff <= pix.dst.alpha;
         for (int c = 0; c < NUM_COLORS; c++) begin
            tsc_ff[c]  <= {8'd0, tint_c[c]} * {8'd0, src_c[c]};
            d255_ff[c] <= {dst_c[c], 8'd0} - {8'd0, dst_c[c]};
         end
      end
   end

   assign inv = UNIT16 - ea_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_MUL]) begin
         for (int c = 0; c < NUM_COLORS; c++) begin
            p_src_ff[c] <= {16'd0, ea_ff} * {16'd0, tsc_ff[c]};
            p_dst_ff[c] <= {16'd0, d255_ff[c]} * {16'd0, inv};
         end
         pa_src_ff <= {ea_ff, 8'd0} - {8'd0, ea_ff};
         pa_dst_ff <= {16'd0, da_ff} * {8'd0, inv};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_SUM]) begin
         for (int c = 0; c < NUM_COLORS; c++) begin
            num_color_ff[c] <= p_src_ff[c] + p_dst_ff[c];
         end
         num_alpha_ff <= pa_src_ff + pa_dst_ff;
      end
   end

   assign num_color = num_color_ff;
   assign num_alpha = num_alpha_ff;

endmodule : tab_front
`default_nettype wire

### design/tab_cdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tab_cdiv
// Stages 4-6: divide by a constant through a reciprocal multiply, one-step
// correction and cap at 255.
// ----------------------------------------------------------------------------
module tab_cdiv import tab_pkg::*; #(
   parameter int     NUM_W   = NUM_COLOR_W,
   parameter longint DIVISOR = DIV_COLOR,
   parameter int     SHIFT   = SHIFT_COLOR
) (
   input  wire logic             clock,
   input  wire pipe_ctrl_type    ctrl,
   input  wire logic [NUM_W-1:0] num,
   output      logic [7:0]       quo
);

   localparam logic [63:0]      RECIP64 = (64'd1 << SHIFT) / 64'(DIVISOR);
   localparam int               RECIP_W = $clog2(RECIP64 + 64'd1);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);
   localparam logic [NUM_W-1:0] DIV_V   = NUM_W'(DIVISOR);

   logic [NUM_W+RECIP_W-1:0] prod;
   logic [NUM_W+8:0]         bound_full;

   logic [7:0]       q0_ff;
   logic [NUM_W-1:0] num_ff;
   logic [7:0]       q0_b_ff;
   logic [NUM_W-1:0] num_b_ff;
   logic [NUM_W:0]   bound_ff;
   logic [8:0]       q_sum;
   logic [7:0]       quo_ff;

   // estimate is exact or one low
   assign prod = {{RECIP_W{1'b0}}, num} * {{NUM_W{1'b0}}, RECIP};

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_RECIP]) begin
         q0_ff  <= prod[SHIFT +: 8];
         num_ff <= num;
      end
   end

   assign bound_full = ({1'b0, q0_ff} + 9'd1) * {{9{1'b0}}, DIV_V};

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_BOUND]) begin
         q0_b_ff  <= q0_ff;
         num_b_ff <= num_ff;
         bound_ff <= bound_full[NUM_W:0];
      end
   end

   assign q_sum = {1'b0, q0_b_ff} + {8'd0, ({1'b0, num_b_ff} >= bound_ff)};

   always_ff @(posedge clock) begin
      if (ctrl.load[STG_OUT]) begin
         quo_ff <= q_sum[8] ? 8'hFF : q_sum[7:0];
      end
   end

   assign quo = quo_ff;

endmodule : tab_cdiv
`default_nettype wire

### design/tinted_alpha_over_blend_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tinted_alpha_over_blend_unit
// Tinted Porter-Duff source-over blend of one RGBA8 pixel onto another.
// ----------------------------------------------------------------------------
// Takes one source/destination pixel pair per clock and returns one blended
// pixel per clock unless the result side stalls, through a six-stage pipeline:
// tint products, blend multiplies, numerator sum, reciprocal multiply,
// correction bound, capped output register. Stalls on the result side fill
// bubbles first; the input drops ready only when all six stages hold beats.
// Tint registers at byte addresses 0 (red), 4 (green), 8 (blue), 12 (alpha),
// reset to 255 (1.0), to be written while no beat is in flight (unchecked).
// ----------------------------------------------------------------------------
module tinted_alpha_over_blend_unit import tab_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tab_req_if.sink                    req_if,
   tab_rsp_if.source                  rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output      logic [31:0]           csr_prdata,
   output      logic                  csr_pready
);

   rgba_type                               tint;
   pipe_ctrl_type                          ctrl;
   pixel_pair_type                         pix;
   logic [NUM_COLORS-1:0][NUM_COLOR_W-1:0] num_color;
   logic [NUM_ALPHA_W-1:0]                 num_alpha;
   logic [NUM_COLORS-1:0][7:0]             quo_color;

   tab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .tint    (tint)
   );

   tab_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .ctrl      (ctrl)
   );

   assign pix.src = '{red: req_if.src_red, green: req_if.src_green,
                      blue: req_if.src_blue, alpha: req_if.src_alpha};
   assign pix.dst = '{red: req_if.dst_red, green: req_if.dst_green,
                      blue: req_if.dst_blue, alpha: req_if.dst_alpha};

   tab_front u_front (
      .clock     (clock),
      .ctrl      (ctrl),
      .tint      (tint),
      .pix       (pix),
      .num_color (num_color),
      .num_alpha (num_alpha)
   );

   for (genvar c = 0; c < NUM_COLORS; c++) begin : g_color
      tab_cdiv #(
         .NUM_W   (NUM_COLOR_W),
         .DIVISOR (DIV_COLOR),
         .SHIFT   (SHIFT_COLOR)
      ) u_div (
         .clock (clock),
         .ctrl  (ctrl),
         .num   (num_color[c]),
         .quo   (quo_color[c])
      );
   end

   tab_cdiv #(
      .NUM_W   (NUM_ALPHA_W),
      .DIVISOR (DIV_ALPHA),
      .SHIFT   (SHIFT_ALPHA)
   ) u_div_alpha (
      .clock (clock),
      .ctrl  (ctrl),
      .num   (num_alpha),
      .quo   (rsp_if.out_alpha)
   );

   assign rsp_if.out_red   = quo_color[0];
   assign rsp_if.out_green = quo_color[1];
   assign rsp_if.out_blue  = quo_color[2];

`ifndef NO_ASSERTIONS
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> ctrl.valid[STG_PROD])
      else $error("accepted beat did not enter first stage");

   a_ready_full : assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (&ctrl.valid))
      else $error("input stalled with a bubble in the pipeline");

   a_last_hold : assert property (@(posedge clock) disable iff (reset)
      (ctrl.valid[STG_OUT] && !rsp_if.ready) |-> !ctrl.load[STG_OUT])
      else $error("output stage reloaded under stall");

   a_tint_alpha_wr : assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite
       && csr_paddr[CSR_ADDR_W-1:2] == REG_TINT_ALPHA)
      |=> tint.alpha == $past(csr_pwdata[7:0]))
      else $error("tint alpha write lost");
`endif

endmodule : tinted_alpha_over_blend_unit
`default_nettype wire
